FILE: rtl/etf_pkg.sv
`default_nettype none

package etf_pkg;

    localparam int FRAC_W    = 28;
    localparam int Z_W       = 47;
    localparam int Z_SQ_W    = 30;
    localparam int MUL_W     = 32;
    localparam int PROD_W    = 64;
    localparam int CNT_W     = 16;
    localparam int IDX_W     = 12;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 31;
    localparam int ESC_W     = 8;

    // 2.0 in the z format and 4.0 in the product format
    localparam logic signed [Z_W-1:0] Z_TWO   = Z_W'(2 ** (FRAC_W + 1));
    localparam logic signed [Z_W-1:0] Z_TWO_N = -Z_TWO;
    localparam logic [PROD_W-1:0]     SQ_FOUR = PROD_W'(1) << (2 * FRAC_W + 2);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_JULIA_MODE  = 3'd0,
        CFG_X_ORIGIN    = 3'd1,
        CFG_Y_ORIGIN    = 3'd2,
        CFG_STEP_SIZE   = 3'd3,
        CFG_ITER_LIMIT  = 3'd4,
        CFG_JULIA_C_RE  = 3'd5,
        CFG_JULIA_C_IM  = 3'd6
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_INIT,
        ST_MUL,
        ST_UPD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0] column;
        logic [IDX_W-1:0] row;
    } t_pix_in;

    typedef struct packed {
        logic [IDX_W-1:0] pixel_column;
        logic [IDX_W-1:0] pixel_row;
        logic [ESC_W-1:0] escape_count;
    } t_pix_out;

    typedef struct packed {
        logic [MUL_W-1:0] a0;
        logic [MUL_W-1:0] b0;
        logic [MUL_W-1:0] a1;
        logic [MUL_W-1:0] b1;
        logic [MUL_W-1:0] a2;
        logic [MUL_W-1:0] b2;
    } t_mul_ops;

    typedef struct packed {
        logic [PROD_W-1:0] p0;
        logic [PROD_W-1:0] p1;
        logic [PROD_W-1:0] p2;
    } t_mul_res;

endpackage

`default_nettype wire

FILE: rtl/etf_mul3.sv
`default_nettype none

// Three signed 32x32 multipliers with registered products.
module etf_mul3 import etf_pkg::*; (
    input  wire logic     i_clk,
    input  wire t_mul_ops i_ops,
    output t_mul_res      o_res
);

    t_mul_res r_res;

    always_ff @(posedge i_clk) begin
        r_res.p0 <= PROD_W'($signed(i_ops.a0) * $signed(i_ops.b0));
        r_res.p1 <= PROD_W'($signed(i_ops.a1) * $signed(i_ops.b1));
        r_res.p2 <= PROD_W'($signed(i_ops.a2) * $signed(i_ops.b2));
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

FILE: rtl/escape_time_fractal_iteration_unit.sv
// Per pixel: ST_MAP and ST_INIT map the indices to a point, then each iteration runs
// ST_MUL and ST_UPD: one pass through the registered multiplier bank, then the compare
// and z update. The limit or box test in ST_MUL or the squared-magnitude compare in ST_UPD
// ends the pixel in ST_DONE, and a new pixel is taken only back in ST_IDLE. A finished
// result waits in the output register and holds the sequencer until it transfers.
// Reset (synchronous, active low) clears the sequencer and output valid, loads defaults.
`default_nettype none

module escape_time_fractal_iteration_unit import etf_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // pixel input
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_pix_in              i_in_data,
    // result output
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_pix_out                  o_out_data,
    // register write port
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic              r_julia_mode;
    logic [31:0]       r_x_origin;
    logic [31:0]       r_y_origin;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_limit;
    logic [31:0]       r_jc_re;
    logic [31:0]       r_jc_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_julia_mode <= 1'b0;
            r_x_origin   <= 32'hE000_0000;
            r_y_origin   <= 32'hE000_0000;
            r_step       <= STEP_W'(1048576);
            r_limit      <= CNT_W'(255);
            r_jc_re      <= '0;
            r_jc_im      <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_JULIA_MODE: r_julia_mode <= i_cfg_wdata[0];
                CFG_X_ORIGIN:   r_x_origin   <= i_cfg_wdata;
                CFG_Y_ORIGIN:   r_y_origin   <= i_cfg_wdata;
                CFG_STEP_SIZE:  r_step       <= i_cfg_wdata[STEP_W-1:0];
                CFG_ITER_LIMIT: r_limit      <= i_cfg_wdata[CNT_W-1:0];
                CFG_JULIA_C_RE: r_jc_re      <= i_cfg_wdata;
                CFG_JULIA_C_IM: r_jc_im      <= i_cfg_wdata;
                default: ;  // unknown index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    t_state                  r_state, n_state;
    logic [IDX_W-1:0]        r_col, n_col;
    logic [IDX_W-1:0]        r_row, n_row;
    logic signed [Z_W-1:0]   r_z_re, n_z_re;
    logic signed [Z_W-1:0]   r_z_im, n_z_im;
    logic signed [Z_W-1:0]   r_c_re, n_c_re;
    logic signed [Z_W-1:0]   r_c_im, n_c_im;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_out_valid, n_out_valid;
    t_pix_out                r_out_data, n_out_data;

    // Shared multiplier bank: maps the pixel in ST_MAP, squares z in ST_MUL
    t_mul_ops                w_ops;
    t_mul_res                w_res;

    etf_mul3 u_mul (
        .i_clk (i_clk),
        .i_ops (w_ops),
        .o_res (w_res)
    );

    logic [MUL_W-1:0]        w_re_op, w_im_op;
    logic signed [Z_W-1:0]   w_p_re, w_p_im;
    logic                    w_in_range;
    logic [PROD_W-1:0]       w_sq_sum;
    logic signed [PROD_W-1:0] w_diff, w_diff_sh, w_cross_sh;
    logic                    w_in_xfer, w_out_free;

    always_comb begin
        // z parts are below 2.0 whenever the products are used: 30 bits carry them
        w_re_op = {{(MUL_W-Z_SQ_W){r_z_re[Z_SQ_W-1]}}, r_z_re[Z_SQ_W-1:0]};
        w_im_op = {{(MUL_W-Z_SQ_W){r_z_im[Z_SQ_W-1]}}, r_z_im[Z_SQ_W-1:0]};

        if (r_state == ST_MAP) begin
            w_ops.a0 = {{(MUL_W-IDX_W){1'b0}}, r_col};
            w_ops.b0 = {{(MUL_W-STEP_W){1'b0}}, r_step};
            w_ops.a1 = {{(MUL_W-IDX_W){1'b0}}, r_row};
            w_ops.b1 = {{(MUL_W-STEP_W){1'b0}}, r_step};
            w_ops.a2 = '0;
            w_ops.b2 = '0;
        end else begin
            w_ops.a0 = w_re_op;
            w_ops.b0 = w_re_op;
            w_ops.a1 = w_im_op;
            w_ops.b1 = w_im_op;
            w_ops.a2 = w_re_op;
            w_ops.b2 = w_im_op;
        end

        // point = origin + index * step; index * step is non-negative and below 2^43
        w_p_re = $signed({{(Z_W-32){r_x_origin[31]}}, r_x_origin})
               + $signed(w_res.p0[Z_W-1:0]);
        w_p_im = $signed({{(Z_W-32){r_y_origin[31]}}, r_y_origin})
               + $signed(w_res.p1[Z_W-1:0]);

        w_in_range = (r_z_re < Z_TWO) && (r_z_re > Z_TWO_N)
                  && (r_z_im < Z_TWO) && (r_z_im > Z_TWO_N);

        w_sq_sum   = w_res.p0 + w_res.p1;
        w_diff     = $signed(w_res.p0) - $signed(w_res.p1);
        // arithmetic shifts round toward minus infinity; 2*re*im folds into the shift
        w_diff_sh  = w_diff >>> FRAC_W;
        w_cross_sh = $signed(w_res.p2) >>> (FRAC_W - 1);

        w_in_xfer  = i_in_valid && (r_state == ST_IDLE);
        w_out_free = !r_out_valid || i_out_ready;
    end

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_z_re      = r_z_re;
        n_z_im      = r_z_im;
        n_c_re      = r_c_re;
        n_c_im      = r_c_im;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;

        unique case (r_state)
            ST_IDLE: begin
                // hold the pixel indices and start the mapping multiply
                if (w_in_xfer) begin
                    n_col   = i_in_data.column;
                    n_row   = i_in_data.row;
                    n_state = ST_MAP;
                end
            end
            ST_MAP: begin
                n_state = ST_INIT;
            end
            ST_INIT: begin
                n_count = '0;
                if (r_julia_mode) begin
                    n_z_re = w_p_re;
                    n_z_im = w_p_im;
                    n_c_re = $signed({{(Z_W-32){r_jc_re[31]}}, r_jc_re});
                    n_c_im = $signed({{(Z_W-32){r_jc_im[31]}}, r_jc_im});
                end else begin
                    n_z_re = '0;
                    n_z_im = '0;
                    n_c_re = w_p_re;
                    n_c_im = w_p_im;
                end
                n_state = ST_MUL;
            end
            ST_MUL: begin
                // limit reached or a part already at 2.0 or beyond: finish
                if ((r_count < r_limit) && w_in_range) begin
                    n_state = ST_UPD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_UPD: begin
                if (w_sq_sum >= SQ_FOUR) begin
                    n_state = ST_DONE;
                end else begin
                    n_z_re  = $signed(w_diff_sh[Z_W-1:0]) + r_c_re;
                    n_z_im  = $signed(w_cross_sh[Z_W-1:0]) + r_c_im;
                    n_count = r_count + CNT_W'(1);
                    n_state = ST_MUL;
                end
            end
            ST_DONE: begin
                // advance only once the output register is free
                if (w_out_free) begin
                    n_out_valid               = 1'b1;
                    n_out_data.pixel_column   = r_col;
                    n_out_data.pixel_row      = r_row;
                    n_out_data.escape_count   = r_count[ESC_W-1:0];
                    n_state                   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col      <= n_col;
        r_row      <= n_row;
        r_z_re     <= n_z_re;
        r_z_im     <= n_z_im;
        r_c_re     <= n_c_re;
        r_c_im     <= n_c_im;
        r_count    <= n_count;
        r_out_data <= n_out_data;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTH
    // an input transfer always starts the mapping step
    a_xfer_to_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == ST_MAP))
        else $error("input transfer did not start mapping");

    // the z update is always preceded by a multiply cycle
    a_upd_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> ($past(r_state) == ST_MUL))
        else $error("update without multiply");

    // the iteration count never passes the limit
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_MUL) || (r_state == ST_UPD)) |-> (r_count <= r_limit))
        else $error("iteration count above limit");

    // a finished pixel waits while the previous result is still held
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && r_out_valid && !i_out_ready) |=> (r_state == ST_DONE))
        else $error("result overwritten before transfer");
`endif

endmodule

`default_nettype wire

FILE: bench/escape_time_fractal_iteration_unit_tb.sv
`timescale 1ns / 100ps

module escape_time_fractal_iteration_unit_tb;
    import etf_pkg::*;

    // Register values after reset
    localparam logic              JULIA_RESET   = 1'b0;
    localparam logic [CFG_W-1:0]  ORIGIN_RESET  = 32'hE000_0000;
    localparam logic [STEP_W-1:0] STEP_RESET    = 31'd1048576;
    localparam logic [CNT_W-1:0]  LIMIT_RESET   = 16'd255;

    // Index that maps to no register; a write to it must leave everything alone
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REGISTER = 3'd7;

    // Escape thresholds: 2.0 in Q.28 and 4.0 in Q.56
    localparam longint ESC_RADIUS = longint'(1) <<< (FRAC_W + 1);
    localparam longint ESC_NORM   = longint'(1) <<< (2 * FRAC_W + 2);

    localparam int IDLE_PERCENT = 30;
    localparam int SHOWN_ERRORS = 10;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 px_valid  = 1'b0;
    logic                 px_ready;
    t_pix_in              px_data   = '0;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    t_pix_out             res_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // Own copy of the register file, kept in step with every write
    logic                 cfg_julia = JULIA_RESET;
    logic signed [31:0]   cfg_x0    = ORIGIN_RESET;
    logic signed [31:0]   cfg_y0    = ORIGIN_RESET;
    logic [STEP_W-1:0]    cfg_step  = STEP_RESET;
    logic [CNT_W-1:0]     cfg_limit = LIMIT_RESET;
    logic signed [31:0]   cfg_cre   = '0;
    logic signed [31:0]   cfg_cim   = '0;

    // Results still owed by the block, oldest first
    t_pix_out expected_pixels[$];

    bit idle_enabled     = 1'b1;
    int sink_hold_cycles = 0;
    int fail_count       = 0;
    int pixels_sent      = 0;
    int results_seen     = 0;
    int views_loaded     = 0;

    escape_time_fractal_iteration_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (px_valid),
        .o_in_ready  (px_ready),
        .i_in_data   (px_data),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_out_data  (res_data),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Turn a real number into signed Q4.28
    function automatic logic [31:0] q28(input real value);
        return 32'($rtoi(value * 268435456.0));
    endfunction

    // Apply a register write to the local copy, with the widths the block keeps
    function automatic void mirror_register(input logic [CFG_IDX_W-1:0] index,
                                            input logic [CFG_W-1:0] value);
        case (index)
            CFG_JULIA_MODE: cfg_julia = value[0];
            CFG_X_ORIGIN:   cfg_x0    = value;
            CFG_Y_ORIGIN:   cfg_y0    = value;
            CFG_STEP_SIZE:  cfg_step  = value[STEP_W-1:0];
            CFG_ITER_LIMIT: cfg_limit = value[CNT_W-1:0];
            CFG_JULIA_C_RE: cfg_cre   = value;
            CFG_JULIA_C_IM: cfg_cim   = value;
            default: ;
        endcase
    endfunction

    // Iterate one pixel under the current registers and return the count mod 256.
    // Arithmetic shift of a signed 64-bit value gives the floor rounding needed.
    function automatic logic [ESC_W-1:0] escape_count_of(input logic [IDX_W-1:0] column,
                                                         input logic [IDX_W-1:0] row);
        longint p_re, p_im, z_re, z_im, c_re, c_im, sq_re, sq_im;
        int unsigned n;
        p_re = longint'(cfg_x0) + longint'(column) * longint'(cfg_step);
        p_im = longint'(cfg_y0) + longint'(row) * longint'(cfg_step);
        if (cfg_julia) begin
            z_re = p_re;
            z_im = p_im;
            c_re = longint'(cfg_cre);
            c_im = longint'(cfg_cim);
        end else begin
            z_re = 0;
            z_im = 0;
            c_re = p_re;
            c_im = p_im;
        end
        n = 0;
        while (n < cfg_limit) begin
            if (z_re >= ESC_RADIUS || z_re <= -ESC_RADIUS ||
                z_im >= ESC_RADIUS || z_im <= -ESC_RADIUS)
                break;
            sq_re = z_re * z_re;
            sq_im = z_im * z_im;
            if (sq_re + sq_im >= ESC_NORM)
                break;
            // imaginary part first: it still needs the old real part
            z_im = ((2 * z_re * z_im) >>> FRAC_W) + c_im;
            z_re = ((sq_re - sq_im) >>> FRAC_W) + c_re;
            n++;
        end
        return n[ESC_W-1:0];
    endfunction

    // One register write; the caller drops the write enable after its last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge clk);
        mirror_register(index, value);
    endtask

    // Load a full view. Bits above each narrow register carry noise, which the
    // block must drop.
    task automatic load_view(input logic julia, input logic [31:0] x0, input logic [31:0] y0,
                             input logic [STEP_W-1:0] step, input logic [CNT_W-1:0] limit,
                             input logic [31:0] cre, input logic [31:0] cim);
        write_reg(CFG_JULIA_MODE, {31'($urandom), julia});
        write_reg(CFG_X_ORIGIN, x0);
        write_reg(CFG_Y_ORIGIN, y0);
        write_reg(CFG_STEP_SIZE, {1'($urandom), step});
        write_reg(CFG_ITER_LIMIT, {16'($urandom), limit});
        write_reg(CFG_JULIA_C_RE, cre);
        write_reg(CFG_JULIA_C_IM, cim);
        cfg_wr_en <= 1'b0;
        views_loaded++;
    endtask

    // Mostly views framed on the interesting region; now and then anything at all
    task automatic load_random_view(input int unsigned lim_lo, input int unsigned lim_hi);
        logic [31:0]       x0, y0, cre, cim;
        logic [STEP_W-1:0] step;
        if ($urandom_range(3, 0) == 0) begin
            x0   = $urandom;
            y0   = $urandom;
            step = 31'($urandom);
        end else begin
            x0   = $urandom_range(32'h3000_0000, 0) - 32'h2000_0000;
            y0   = $urandom_range(32'h3000_0000, 0) - 32'h2000_0000;
            step = 31'($urandom_range(32'd1 << $urandom_range(20, 2), 1));
        end
        if ($urandom_range(4, 0) == 0) begin
            cre = $urandom;
            cim = $urandom;
        end else begin
            cre = $urandom_range(32'h2000_0000, 0) - 32'h1000_0000;
            cim = $urandom_range(32'h2000_0000, 0) - 32'h1000_0000;
        end
        load_view(1'($urandom), x0, y0, step, 16'($urandom_range(lim_hi, lim_lo)), cre, cim);
    endtask

    // Offer one pixel, hold it until the transfer, and log what must come back.
    // Valid stays high on return so back-to-back pixels need no gap.
    task automatic send_pixel(input logic [IDX_W-1:0] column, input logic [IDX_W-1:0] row);
        t_pix_in  px;
        t_pix_out want;
        if (idle_enabled) begin
            while ($urandom_range(99, 0) < IDLE_PERCENT) begin
                px_valid <= 1'b0;
                @(posedge clk);
            end
        end
        px.column = column;
        px.row    = row;
        px_valid <= 1'b1;
        px_data  <= px;
        do @(posedge clk); while (!px_ready);
        want.pixel_column = column;
        want.pixel_row    = row;
        want.escape_count = escape_count_of(column, row);
        expected_pixels.push_back(want);
        pixels_sent++;
    endtask

    // Drop valid and let every owed result arrive before the registers change
    task automatic wait_for_results;
        px_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_reset_defaults;
        // corner, the point -1.5-1.5i and the far corner
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd128, 12'd128);
        send_pixel(12'd4095, 12'd4095);
        wait_for_results;
    endtask

    task automatic test_field_extremes;
        // most negative origin, most positive origin, widest step
        load_view(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 16'd255,
                  32'h8000_0000, 32'h7FFF_FFFF);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd4095);
        wait_for_results;
        load_view(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 16'd255,
                  32'h8000_0000, 32'h7FFF_FFFF);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        wait_for_results;
    endtask

    task automatic test_escape_boundaries;
        // Julia start exactly on -2 and one step inside it, on each axis:
        // covers the box test on either part and the squared-norm test
        load_view(1'b1, q28(-2.0), q28(-2.0), 31'd1, 16'd20, '0, '0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd0);
        send_pixel(12'd0, 12'd1);
        send_pixel(12'd1, 12'd1);
        wait_for_results;
        // Mandelbrot c = -2, 0 and +2 on the real axis
        load_view(1'b0, q28(-2.0), '0, STEP_W'(q28(1.0)), 16'd20, '0, '0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd2, 12'd0);
        send_pixel(12'd4, 12'd0);
        wait_for_results;
    endtask

    task automatic test_limit_cases;
        logic [CNT_W-1:0] limits[5];
        // zero limit, one, count wrapping to zero, wrapping past it, the largest
        limits = '{16'd0, 16'd1, 16'd256, 16'd300, 16'd65535};
        foreach (limits[k]) begin
            load_view(1'b0, '0, '0, 31'd1, limits[k], '0, '0);
            send_pixel(12'd0, 12'd0);
            wait_for_results;
        end
    endtask

    task automatic test_zero_step;
        // every pixel lands on the origin, whatever its index
        load_view(1'b1, q28(0.1), q28(-0.3), '0, 16'd100, q28(-0.8), q28(0.156));
        send_pixel(12'd4095, 12'd17);
        send_pixel(12'd3, 12'd4000);
        wait_for_results;
    endtask

    task automatic test_unknown_register;
        write_reg(CFG_NO_REGISTER, '1);
        cfg_wr_en <= 1'b0;
        send_pixel(12'd10, 12'd20);
        send_pixel(12'd2048, 12'd1);
        wait_for_results;
    endtask

    task automatic test_random_views(input int phases, input int items,
                                     input int unsigned lim_lo, input int unsigned lim_hi);
        for (int p = 0; p < phases; p++) begin
            load_random_view(lim_lo, lim_hi);
            for (int i = 0; i < items; i++) begin
                // mostly anywhere in the index space, some near the origin corner
                if ($urandom_range(4, 0) == 0)
                    send_pixel(12'($urandom_range(63, 0)), 12'($urandom_range(63, 0)));
                else
                    send_pixel(12'($urandom), 12'($urandom));
            end
            wait_for_results;
        end
    endtask

    task automatic test_no_idle_stretch;
        idle_enabled = 1'b0;
        load_random_view(0, 24);
        repeat (150) send_pixel(12'($urandom), 12'($urandom));
        wait_for_results;
        idle_enabled = 1'b1;
    endtask

    task automatic test_output_backpressure;
        // short pixels, receiver held off: the block fills and stalls its input
        idle_enabled = 1'b0;
        load_random_view(0, 6);
        sink_hold_cycles = 300;
        repeat (60) send_pixel(12'($urandom), 12'($urandom));
        wait_for_results;
        idle_enabled = 1'b1;
    endtask

    // Result side: check each transfer against the oldest owed result, then
    // choose ready for the next cycle
    initial begin : result_sink
        t_pix_out want;
        forever begin
            @(posedge clk);
            if (rst_n && res_valid && res_ready) begin
                results_seen++;
                if (expected_pixels.size() == 0) begin
                    fail_count++;
                    if (fail_count <= SHOWN_ERRORS)
                        $display("%0t: result with nothing owed: col %0d row %0d count %0d",
                                 $time, res_data.pixel_column, res_data.pixel_row,
                                 res_data.escape_count);
                end else begin
                    want = expected_pixels.pop_front();
                    if (res_data.pixel_column !== want.pixel_column ||
                        res_data.pixel_row !== want.pixel_row ||
                        res_data.escape_count !== want.escape_count) begin
                        fail_count++;
                        if (fail_count <= SHOWN_ERRORS)
                            $display("%0t: mismatch: expected col %0d row %0d count %0d, got col %0d row %0d count %0d",
                                     $time, want.pixel_column, want.pixel_row,
                                     want.escape_count, res_data.pixel_column,
                                     res_data.pixel_row, res_data.escape_count);
                    end
                end
            end
            // hold off while a stall is requested, else idle at random
            if (sink_hold_cycles > 0) begin
                sink_hold_cycles--;
                res_ready <= 1'b0;
            end else if (idle_enabled && $urandom_range(99, 0) < IDLE_PERCENT) begin
                res_ready <= 1'b0;
            end else begin
                res_ready <= 1'b1;
            end
        end
    end

    // Stop a hung run
    initial begin : watchdog
        #50_000_000;
        $display("timeout with %0d results still owed", expected_pixels.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin : sequencer
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults;
        test_field_extremes;
        test_escape_boundaries;
        test_limit_cases;
        test_zero_step;
        test_unknown_register;
        test_random_views(7, 170, 0, 48);
        test_random_views(1, 120, 200, 255);
        test_no_idle_stretch;
        test_output_backpressure;

        wait_for_results;
        repeat (20) @(posedge clk);

        $display("%0d pixels sent, %0d results checked over %0d register views.",
                 pixels_sent, results_seen, views_loaded);
        $display("Covered both modes, limits 0 to 65535, zero step, escape edges and stalls.");
        if (fail_count == 0 && expected_pixels.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d failures", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: escape_time_fractal_iteration_unit.f
rtl/etf_pkg.sv
rtl/etf_mul3.sv
rtl/escape_time_fractal_iteration_unit.sv
bench/escape_time_fractal_iteration_unit_tb.sv
